// ===== hw/rtl/vhd_pkg.sv =====
// ----------------------------------------------------------------------------
// vhd_pkg
// Shared types, widths and the arctangent table for the heading pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vhd_pkg;

    localparam int DATA_W     = 44;
    localparam int SCALE_BITS = 40;
    localparam int ANGLE_W    = 24;
    localparam int TOTAL_W    = 24;
    localparam int HEAD_W     = 16;
    localparam int TABLE_LEN  = 24;
    localparam int FRAC_BITS  = 8;
    localparam int ATAN_W     = 21;

    localparam logic [TOTAL_W-1:0] QUARTER_UNITS = 24'd2949120;
    localparam logic [TOTAL_W-1:0] BASE_UP       = 24'd0;
    localparam logic [TOTAL_W-1:0] BASE_RIGHT    = 24'd2949120;
    localparam logic [TOTAL_W-1:0] BASE_DOWN     = 24'd5898240;
    localparam logic [TOTAL_W-1:0] BASE_LEFT     = 24'd8847360;
    localparam logic [TOTAL_W-1:0] ROUND_HALF    = 24'd128;
    localparam logic [HEAD_W-1:0]  FULL_TURN     = 16'd46080;

    typedef enum logic [1:0] {
        QUAD_UP    = 2'd0,
        QUAD_RIGHT = 2'd1,
        QUAD_DOWN  = 2'd2,
        QUAD_LEFT  = 2'd3
    } vhd_quad_t;

    typedef struct packed {
        logic      special;
        vhd_quad_t quad;
    } vhd_tag_t;

    // atan(2^-i) in 1/32768 degree, rounded
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 21'd1474560;
            5'd1:    val = 21'd870484;
            5'd2:    val = 21'd459940;
            5'd3:    val = 21'd233473;
            5'd4:    val = 21'd117189;
            5'd5:    val = 21'd58652;
            5'd6:    val = 21'd29333;
            5'd7:    val = 21'd14667;
            5'd8:    val = 21'd7334;
            5'd9:    val = 21'd3667;
            5'd10:   val = 21'd1833;
            5'd11:   val = 21'd917;
            5'd12:   val = 21'd458;
            5'd13:   val = 21'd229;
            5'd14:   val = 21'd115;
            5'd15:   val = 21'd57;
            5'd16:   val = 21'd29;
            5'd17:   val = 21'd14;
            5'd18:   val = 21'd7;
            5'd19:   val = 21'd4;
            5'd20:   val = 21'd2;
            5'd21:   val = 21'd1;
            default: val = 21'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/vhd_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// vhd_cordic_stage
// One vectoring micro-rotation with its own valid bit and ready chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vhd_cordic_stage
    import vhd_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [DATA_W-1:0]  x_in,
    input  logic signed [DATA_W-1:0]  y_in,
    input  logic signed [ANGLE_W-1:0] z_in,
    input  vhd_tag_t                  tag_in,
    output logic                      down_valid,
    input  logic                      down_ready,
    output logic signed [DATA_W-1:0]  x_out,
    output logic signed [DATA_W-1:0]  y_out,
    output logic signed [ANGLE_W-1:0] z_out,
    output vhd_tag_t                  tag_out
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  x_next;
    logic signed [DATA_W-1:0]  y_reg;
    logic signed [DATA_W-1:0]  y_next;
    logic signed [ANGLE_W-1:0] z_reg;
    logic signed [ANGLE_W-1:0] z_next;
    vhd_tag_t                  tag_reg;
    logic signed [DATA_W-1:0]  x_shift;
    logic signed [DATA_W-1:0]  y_shift;
    logic signed [ANGLE_W-1:0] step_angle;
    logic                      load;

    assign up_ready   = !valid_reg || down_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    assign x_shift    = x_in >>> SHIFT;
    assign y_shift    = y_in >>> SHIFT;
    assign step_angle = signed'(ANGLE_W'(atan_entry(5'(SHIFT))));

    always_comb
    begin
        if (!y_in[DATA_W-1])
        begin
            x_next = x_in + y_shift;
            y_next = y_in - x_shift;
            z_next = z_in + step_angle;
        end
        else
        begin
            x_next = x_in - y_shift;
            y_next = y_in + x_shift;
            z_next = z_in - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign down_valid = valid_reg;
    assign x_out      = x_reg;
    assign y_out      = y_reg;
    assign z_out      = z_reg;
    assign tag_out    = tag_reg;

endmodule

// ===== hw/rtl/vector_heading_degrees_top.sv =====
// ----------------------------------------------------------------------------
// vector_heading_degrees_top
// Clockwise heading from up of a screen vector, 1/128 degree, via CORDIC.
// Registered path from accepted item to result: fold register, one
// register per micro-rotation, clamp/base add, round/wrap.
// Throughput: one item per cycle unless stalled; stalled stages hold items.
// Reset clears only the valid bits; the datapath needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_heading_degrees_top
    import vhd_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [HEAD_W-1:0]  heading
);

    localparam int STEPS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SCALE_SH = SCALE_BITS - COMPONENT_WIDTH;

    // component extraction and quadrant fold
    logic [31:0]                       ext_x;
    logic [31:0]                       ext_y;
    logic signed [COMPONENT_WIDTH-1:0] comp_x;
    logic signed [COMPONENT_WIDTH-1:0] comp_y;
    logic signed [DATA_W-1:0]          wide_x;
    logic signed [DATA_W-1:0]          wide_y;
    logic signed [DATA_W-1:0]          mag_a;
    logic signed [DATA_W-1:0]          mag_b;
    logic                              dx_zero;
    logic                              dy_zero;
    logic                              dx_neg;
    logic                              dy_neg;
    vhd_tag_t                          fold_tag;

    logic                              fold_valid_reg;
    logic                              fold_valid_next;
    logic signed [DATA_W-1:0]          fold_x_reg;
    logic signed [DATA_W-1:0]          fold_y_reg;
    vhd_tag_t                          fold_tag_reg;

    logic [STEPS:0]                    pipe_valid;
    logic [STEPS:0]                    pipe_ready;
    logic signed [DATA_W-1:0]          x_pipe [STEPS+1];
    logic signed [DATA_W-1:0]          y_pipe [STEPS+1];
    logic signed [ANGLE_W-1:0]         z_pipe [STEPS+1];
    vhd_tag_t                          tag_pipe [STEPS+1];

    // clamp and base add
    logic                              sum_valid_reg;
    logic                              sum_valid_next;
    logic                              sum_ready;
    logic [TOTAL_W-1:0]                sum_reg;
    logic [TOTAL_W-1:0]                sum_next;
    logic [TOTAL_W-1:0]                angle_clamped;
    logic [TOTAL_W-1:0]                base_units;

    // round and wrap
    logic                              head_valid_reg;
    logic                              head_valid_next;
    logic                              head_ready;
    logic [HEAD_W-1:0]                 head_reg;
    logic [HEAD_W-1:0]                 head_next;
    logic [TOTAL_W-1:0]                rounded;

    assign ext_x   = {16'd0, delta_x};
    assign ext_y   = {16'd0, delta_y};
    assign comp_x  = signed'(ext_x[COMPONENT_WIDTH-1:0]);
    assign comp_y  = signed'(ext_y[COMPONENT_WIDTH-1:0]);
    assign wide_x  = DATA_W'(comp_x);
    assign wide_y  = DATA_W'(comp_y);
    assign dx_zero = (comp_x == '0);
    assign dy_zero = (comp_y == '0);
    assign dx_neg  = comp_x[COMPONENT_WIDTH-1];
    assign dy_neg  = comp_y[COMPONENT_WIDTH-1];

    always_comb
    begin
        fold_tag.special = 1'b0;
        fold_tag.quad    = QUAD_UP;
        mag_a            = '0;
        mag_b            = '0;
        if (dx_zero)
        begin
            fold_tag.special = 1'b1;
            fold_tag.quad    = (!dy_neg && !dy_zero) ? QUAD_DOWN : QUAD_UP;
        end
        else if (dy_zero)
        begin
            fold_tag.special = 1'b1;
            fold_tag.quad    = dx_neg ? QUAD_LEFT : QUAD_RIGHT;
        end
        else if (!dx_neg && dy_neg)
        begin
            fold_tag.quad = QUAD_UP;
            mag_a         = -wide_y;
            mag_b         = wide_x;
        end
        else if (!dx_neg)
        begin
            fold_tag.quad = QUAD_RIGHT;
            mag_a         = wide_x;
            mag_b         = wide_y;
        end
        else if (!dy_neg)
        begin
            fold_tag.quad = QUAD_DOWN;
            mag_a         = wide_y;
            mag_b         = -wide_x;
        end
        else
        begin
            fold_tag.quad = QUAD_LEFT;
            mag_a         = -wide_x;
            mag_b         = -wide_y;
        end
    end

    assign in_ready        = !fold_valid_reg || pipe_ready[0];
    assign fold_valid_next = in_ready ? in_valid : fold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else
        begin
            fold_valid_reg <= fold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fold_x_reg   <= mag_a <<< SCALE_SH;
            fold_y_reg   <= mag_b <<< SCALE_SH;
            fold_tag_reg <= fold_tag;
        end
    end

    assign pipe_valid[0] = fold_valid_reg;
    assign x_pipe[0]     = fold_x_reg;
    assign y_pipe[0]     = fold_y_reg;
    assign z_pipe[0]     = '0;
    assign tag_pipe[0]   = fold_tag_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_rot
        vhd_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (pipe_valid[k]),
            .up_ready   (pipe_ready[k]),
            .x_in       (x_pipe[k]),
            .y_in       (y_pipe[k]),
            .z_in       (z_pipe[k]),
            .tag_in     (tag_pipe[k]),
            .down_valid (pipe_valid[k+1]),
            .down_ready (pipe_ready[k+1]),
            .x_out      (x_pipe[k+1]),
            .y_out      (y_pipe[k+1]),
            .z_out      (z_pipe[k+1]),
            .tag_out    (tag_pipe[k+1])
        );
    end

    assign pipe_ready[STEPS] = sum_ready;

    // clamp to a quarter turn (zero on an axis or below zero), then add the quadrant base
    always_comb
    begin
        if (tag_pipe[STEPS].special || z_pipe[STEPS][ANGLE_W-1])
        begin
            angle_clamped = '0;
        end
        else if (TOTAL_W'(z_pipe[STEPS]) > QUARTER_UNITS)
        begin
            angle_clamped = QUARTER_UNITS;
        end
        else
        begin
            angle_clamped = TOTAL_W'(z_pipe[STEPS]);
        end
    end

    always_comb
    begin
        case (tag_pipe[STEPS].quad)
            QUAD_UP:    base_units = BASE_UP;
            QUAD_RIGHT: base_units = BASE_RIGHT;
            QUAD_DOWN:  base_units = BASE_DOWN;
            QUAD_LEFT:  base_units = BASE_LEFT;
            default:    base_units = BASE_UP;
        endcase
    end

    assign sum_next       = base_units + angle_clamped;
    assign sum_ready      = !sum_valid_reg || head_ready;
    assign sum_valid_next = sum_ready ? pipe_valid[STEPS] : sum_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_valid[STEPS] && sum_ready)
        begin
            sum_reg <= sum_next;
        end
    end

    // round half up to 1/128 degree, full turn wraps to zero
    assign rounded = sum_reg + ROUND_HALF;

    always_comb
    begin
        head_next = rounded[TOTAL_W-1:FRAC_BITS];
        if (head_next >= FULL_TURN)
        begin
            head_next = head_next - FULL_TURN;
        end
    end

    assign head_ready      = !head_valid_reg || out_ready;
    assign head_valid_next = head_ready ? sum_valid_reg : head_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid_reg && head_ready)
        begin
            head_reg <= head_next;
        end
    end

    assign out_valid = head_valid_reg;
    assign heading   = head_reg;

endmodule

// ===== hw/rtl/vhd_checker.sv =====
// ----------------------------------------------------------------------------
// vhd_checker
// Port-level checks for the heading pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vhd_checker
    import vhd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [HEAD_W-1:0]  heading
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading))
    else $error("stalled result changed");

    // heading stays below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading < FULL_TURN)
    else $error("heading out of range");

    // a free output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready || !out_valid |-> in_ready)
    else $error("input blocked while output side free");

    // input blocked only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

endmodule

bind vector_heading_degrees_top vhd_checker u_vhd_checker (.*);
